[rtl/lms_pkg.sv]
// Shared types and constants for the LMS adaptive FIR block.
package lms_pkg;

  localparam int TAPS_DEF = 4;

  localparam int SAMP_W = 16;
  localparam int COEF_W = 32;
  localparam int MU_W   = 16;

  // Q3.45 dot product down to Q1.15, and Q3.46 update down to Q2.30
  localparam int ACC_SHIFT = 30;
  localparam int UPD_SHIFT = 16;

  localparam logic [MU_W-1:0] STEP_RESET = 16'd3277;

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample_in;
    logic signed [SAMP_W-1:0] desired_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] filter_out;
    logic signed [SAMP_W-1:0] error_out;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic mac_step;
    logic calc_err;
    logic calc_mue;
    logic upd_step;
    logic load_out;
  } dp_cmd_t;

endpackage

[rtl/lms_datapath.sv]
// Datapath: delay line, coefficients, shared MAC, error and update arithmetic.
module lms_datapath #(
  parameter int TAPS = lms_pkg::TAPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lms_pkg::dp_cmd_t            cmd,
  input  lms_pkg::in_word_t           in_word,
  input  logic                        cfg_we,
  input  logic [lms_pkg::MU_W-1:0]    cfg_data,
  output lms_pkg::out_word_t          out_word
);

  localparam int SW    = lms_pkg::SAMP_W;
  localparam int CW    = lms_pkg::COEF_W;
  localparam int PW    = SW + CW;
  localparam int ACC_W = PW + $clog2(TAPS) + 1;
  localparam int MUE_W = lms_pkg::MU_W + SW + 1;
  localparam int UPW   = MUE_W + SW;
  localparam int UQW   = UPW - lms_pkg::UPD_SHIFT;

  localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W+1)'(1) << (lms_pkg::ACC_SHIFT - 1);
  localparam logic signed [ACC_W:0] Y_MAX    = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0] Y_MIN    = -(ACC_W+1)'(32768);
  localparam logic signed [UPW-1:0] UPD_HALF = UPW'(1) << (lms_pkg::UPD_SHIFT - 1);

  logic signed [SW-1:0]    dl_r [TAPS];
  logic signed [CW-1:0]    w_r  [TAPS];
  logic signed [SW-1:0]    desired_r;
  logic signed [PW-1:0]    prod_r;
  logic                    mac_vld_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SW-1:0]    y_r;
  logic signed [SW-1:0]    e_r;
  logic signed [MUE_W-1:0] mue_r;
  logic signed [UPW-1:0]   uprod_r;
  logic                    upd_vld_r;
  logic [lms_pkg::MU_W-1:0] mu_r;
  lms_pkg::out_word_t      out_word_r;

  logic signed [ACC_W:0]   acc_rnd;
  logic signed [ACC_W:0]   acc_q;
  logic signed [SW-1:0]    y_sat;
  logic signed [SW:0]      e_diff;
  logic signed [SW-1:0]    e_sat;
  logic signed [UPW-1:0]   upd_rnd;
  logic signed [UQW-1:0]   upd_q;
  logic signed [CW+1:0]    w_sum;
  logic signed [CW-1:0]    w_new;

  always_comb begin
    acc_rnd = $signed({acc_r[ACC_W-1], acc_r}) + ACC_HALF;
    acc_q   = acc_rnd >>> lms_pkg::ACC_SHIFT;
    if (acc_q > Y_MAX) begin
      y_sat = SW'(32767);
    end else if (acc_q < Y_MIN) begin
      y_sat = -SW'(32768);
    end else begin
      y_sat = acc_q[SW-1:0];
    end
    e_diff = $signed({desired_r[SW-1], desired_r}) - $signed({y_sat[SW-1], y_sat});
    if (e_diff[SW] != e_diff[SW-1]) begin
      e_sat = e_diff[SW] ? -SW'(32768) : SW'(32767);
    end else begin
      e_sat = e_diff[SW-1:0];
    end
  end

  always_comb begin
    upd_rnd = uprod_r + UPD_HALF;
    upd_q   = upd_rnd[UPW-1:lms_pkg::UPD_SHIFT];
    w_sum   = $signed({{2{w_r[0][CW-1]}}, w_r[0]}) + (CW+2)'(upd_q);
    if (w_sum[CW+1:CW-1] != 3'b000 && w_sum[CW+1:CW-1] != 3'b111) begin
      w_new = w_sum[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      w_new = w_sum[CW-1:0];
    end
  end

  // control state and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_vld_r <= 1'b0;
      upd_vld_r <= 1'b0;
      mu_r      <= lms_pkg::STEP_RESET;
      for (int i = 0; i < TAPS; i++) begin
        dl_r[i] <= '0;
        w_r[i]  <= '0;
      end
    end else begin
      mac_vld_r <= cmd.mac_step;
      upd_vld_r <= cmd.upd_step;
      if (cfg_we) begin
        mu_r <= cfg_data;
      end
      // shift in on accept, rotate by one on each MAC or update product
      if (cmd.accept) begin
        dl_r[0] <= in_word.sample_in;
        for (int i = 1; i < TAPS; i++) begin
          dl_r[i] <= dl_r[i-1];
        end
      end else if (cmd.mac_step || cmd.upd_step) begin
        dl_r[TAPS-1] <= dl_r[0];
        for (int i = 0; i < TAPS - 1; i++) begin
          dl_r[i] <= dl_r[i+1];
        end
      end
      if (cmd.mac_step) begin
        w_r[TAPS-1] <= w_r[0];
        for (int i = 0; i < TAPS - 1; i++) begin
          w_r[i] <= w_r[i+1];
        end
      end else if (upd_vld_r) begin
        w_r[TAPS-1] <= w_new;
        for (int i = 0; i < TAPS - 1; i++) begin
          w_r[i] <= w_r[i+1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      desired_r <= in_word.desired_in;
      acc_r     <= '0;
    end else if (mac_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    prod_r  <= dl_r[0] * w_r[0];
    uprod_r <= mue_r * dl_r[0];
    if (cmd.calc_err) begin
      y_r <= y_sat;
      e_r <= e_sat;
    end
    if (cmd.calc_mue) begin
      mue_r <= $signed({1'b0, mu_r}) * e_r;
    end
    if (cmd.load_out) begin
      out_word_r.filter_out <= y_r;
      out_word_r.error_out  <= e_r;
    end
  end

  assign out_word = out_word_r;

endmodule

[rtl/lms_ctrl.sv]
// Sequencer: steps the MAC pass, error, update pass and output hand-off.
module lms_ctrl #(
  parameter int TAPS = lms_pkg::TAPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output logic             idle,
  output lms_pkg::dp_cmd_t cmd
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_MDRAIN,
    S_ERR,
    S_MUE,
    S_UPD,
    S_UDRAIN,
    S_HOLD
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.mac_step = (state_r == S_MAC);
    cmd.calc_err = (state_r == S_ERR);
    cmd.calc_mue = (state_r == S_MUE);
    cmd.upd_step = (state_r == S_UPD);
    cmd.load_out = (state_r == S_UDRAIN || state_r == S_HOLD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_valid) begin
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_MDRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MDRAIN: state_r <= S_ERR;
        S_ERR:    state_r <= S_MUE;
        S_MUE:    state_r <= S_UPD;
        S_UPD: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_UDRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        // hold the result until the output register frees up
        S_UDRAIN, S_HOLD: begin
          state_r <= out_free ? S_IDLE : S_HOLD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign idle      = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/lms_adaptive_fir_top.sv]
// Top level of the LMS adaptive FIR filter.
//
//  channel  ports                             direction  moves
//  input    in_valid, in_stall, in_word       in         sample_in, desired_in
//  result   out_valid, out_stall, out_word    out        filter_out, error_out
//  config   cfg_valid, cfg_ready, cfg_data    in         step_size (mu, Q0.16)
//
// A word goes from acceptance to result through a dot-product pass over the
// taps on the shared MAC multiplier, the error step and a pass that updates
// the coefficients in turn. A new word is taken in the idle cycle after the
// result is loaded, so no new word is taken while one is in flight.
// Reset is synchronous: delay line and coefficients clear, step_size returns
// to 3277. A stalled result holds in the output register; the next result
// then waits in the sequencer and the input stays stalled.
module lms_adaptive_fir_top #(
  parameter int TAPS = lms_pkg::TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lms_pkg::in_word_t        in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lms_pkg::out_word_t       out_word,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lms_pkg::MU_W-1:0] cfg_data
);

  lms_pkg::dp_cmd_t cmd;
  logic             idle;

  assign cfg_ready = idle;

  lms_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .idle      (idle),
    .cmd       (cmd)
  );

  lms_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_word (out_word)
  );

  // a word in starts a busy period
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but sequencer not busy");

  // results are loaded only at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in flight");

  // at most one of accept, MAC step and update step per cycle
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mac_step && cmd.upd_step) && !(cmd.accept && (cmd.mac_step || cmd.upd_step)))
    else $error("conflicting datapath commands");

endmodule

[tb/tb_lms_adaptive_fir_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LMS adaptive FIR top level, with its own filter model.
module tb_lms_adaptive_fir_top;

  localparam int TAPS            = lms_pkg::TAPS_DEF;
  localparam int SAMP_W          = lms_pkg::SAMP_W;
  localparam int COEF_W          = lms_pkg::COEF_W;
  localparam int MU_W            = lms_pkg::MU_W;
  localparam int LATENCY         = 2 * TAPS + 5;
  localparam int QUIET_LIMIT     = 2000;
  localparam int WORDS_PER_PHASE = 250;
  localparam int PHASES          = 8;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DIR_N           = 25;

  typedef struct packed {
    bit                       set_mu;
    logic [MU_W-1:0]          mu;
    logic signed [SAMP_W-1:0] smp;
    logic signed [SAMP_W-1:0] des;
    bit                       typed;
    logic signed [SAMP_W-1:0] fir;
    logic signed [SAMP_W-1:0] err;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  lms_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  lms_pkg::out_word_t out_word;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [MU_W-1:0]    cfg_data;

  // typed-in expectation that travels with the word being offered
  logic               tag_typed;
  lms_pkg::out_word_t tag_word;

  // filter model: delay line, coefficients, step size
  logic signed [SAMP_W-1:0] dline_q [TAPS];
  logic signed [COEF_W-1:0] coef_q  [TAPS];
  logic [MU_W-1:0]          mu_q;

  lms_pkg::out_word_t filter_results_q [$];
  int                 errors;
  int                 words_out;
  int                 quiet_cycles;
  bit                 idle_on;
  dir_row_t           dir_tab [DIR_N];

  lms_adaptive_fir_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // add half an LSB, then floor
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic lms_pkg::out_word_t lms_filter_step(input lms_pkg::in_word_t w);
    int                 i;
    longint             acc;
    longint             y;
    longint             e;
    longint             upd;
    lms_pkg::out_word_t r;
    for (i = TAPS - 1; i > 0; i--) dline_q[i] = dline_q[i - 1];
    dline_q[0] = w.sample_in;
    acc = 0;
    for (i = 0; i < TAPS; i++) acc += longint'(dline_q[i]) * longint'(coef_q[i]);
    y = clamp(round_shift(acc, lms_pkg::ACC_SHIFT), -32768, 32767);
    e = clamp(longint'(w.desired_in) - y, -32768, 32767);
    for (i = 0; i < TAPS; i++) begin
      upd = longint'(mu_q) * e * longint'(dline_q[i]);
      coef_q[i] = clamp(longint'(coef_q[i]) + round_shift(upd, lms_pkg::UPD_SHIFT),
                        -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);
    end
    r.filter_out = y[SAMP_W-1:0];
    r.error_out  = e[SAMP_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMP_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    if (r < 3) return SAMP_W'($urandom_range(0, 511) - 256);
    return SAMP_W'($urandom);
  endfunction

  // model update, expectation queue, result check
  always @(posedge clk) begin : track
    lms_pkg::out_word_t predicted;
    lms_pkg::out_word_t want;
    int                 i;
    if (!rst_n) begin
      for (i = 0; i < TAPS; i++) begin
        dline_q[i] = '0;
        coef_q[i]  = '0;
      end
      mu_q = lms_pkg::STEP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) mu_q = cfg_data;
      if (in_valid && !in_stall) begin
        predicted = lms_filter_step(in_word);
        filter_results_q.push_back(tag_typed ? tag_word : predicted);
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (filter_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, filter_out %0d error_out %0d", $time,
                   out_word.filter_out, out_word.error_out);
        end else begin
          want = filter_results_q.pop_front();
          if (out_word.filter_out !== want.filter_out) begin
            errors++;
            $display("%0t: filter_out expected %0d, got %0d", $time,
                     want.filter_out, out_word.filter_out);
          end
          if (out_word.error_out !== want.error_out) begin
            errors++;
            $display("%0t: error_out expected %0d, got %0d", $time,
                     want.error_out, out_word.error_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_lms_adaptive_fir_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off so the input backs up
  initial begin : sink
    int stall_left;
    bit held;
    out_stall = 1'b0;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_out >= HOLD_OFF_AT) begin
        held = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic signed [SAMP_W-1:0] s, input logic signed [SAMP_W-1:0] d,
                           input bit typed, input lms_pkg::out_word_t want);
    int                gap;
    lms_pkg::in_word_t w;
    w.sample_in  = s;
    w.desired_in = d;
    in_word   <= w;
    tag_typed <= typed;
    tag_word  <= want;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, drain everything in flight, let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filter_results_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_step_size(input logic [MU_W-1:0] v);
    wait_drained();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim
    int                       k;
    int                       p;
    int                       n;
    int                       dv;
    logic signed [SAMP_W-1:0] s;
    logic signed [SAMP_W-1:0] prev;
    logic [MU_W-1:0]          phase_mu [PHASES];
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    tag_typed = 1'b0;
    tag_word  = '0;
    errors    = 0;
    words_out = 0;
    idle_on   = 1'b1;
    rst_n     = 1'b0;

    // zero samples keep the coefficients at zero, so the output stays 0 and
    // error equals desired until the first nonzero sample has been used
    dir_tab = '{
      '{0, 0,      0,      32767,  1, 0, 32767},
      '{0, 0,      0,      -32768, 1, 0, -32768},
      '{0, 0,      0,      0,      1, 0, 0},
      '{0, 0,      0,      -1,     1, 0, -1},
      '{0, 0,      32767,  -32768, 1, 0, -32768},
      '{0, 0,      -32768, 32767,  0, 0, 0},
      '{0, 0,      1,      -1,     0, 0, 0},
      '{0, 0,      -1,     1,      0, 0, 0},
      '{0, 0,      12345,  -23456, 0, 0, 0},
      '{1, 0,      -32768, -32768, 0, 0, 0},
      '{0, 0,      32767,  32767,  0, 0, 0},
      '{1, 32768,  3,      5,      0, 0, 0},
      '{0, 0,      -7,     11,     0, 0, 0},
      '{0, 0,      255,    -256,   0, 0, 0},
      // full step size with a constant drive diverges: coefficients, output
      // and error all run into saturation
      '{1, 65535,  32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      32767,  -32768, 0, 0, 0},
      '{0, 0,      -32768, 32767,  0, 0, 0},
      '{0, 0,      -32768, 32767,  0, 0, 0}
    };
    phase_mu = '{lms_pkg::STEP_RESET, 16'd0, 16'hffff, 16'h8000, 16'd1,
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 lms_pkg::STEP_RESET};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_N; k++) begin
      if (dir_tab[k].set_mu) write_step_size(dir_tab[k].mu);
      send_word(dir_tab[k].smp, dir_tab[k].des, dir_tab[k].typed,
                {dir_tab[k].fir, dir_tab[k].err});
    end

    prev = '0;
    for (p = 0; p < PHASES; p++) begin
      write_step_size(phase_mu[p]);
      idle_on = (p != 2) && (p != 5);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        s = pick_value();
        // mostly identify a fixed two-tap system, sometimes pure noise
        if ($urandom_range(0, 9) < 8) begin
          dv = (int'(s) >>> 1) - (int'(prev) >>> 2) + int'($urandom_range(0, 15)) - 8;
          send_word(s, dv[SAMP_W-1:0], 1'b0, '0);
        end else begin
          send_word(s, pick_value(), 1'b0, '0);
        end
        prev = s;
      end
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("tb_lms_adaptive_fir_top: clean");
    end else begin
      $display("tb_lms_adaptive_fir_top: errors");
    end
    $finish;
  end

endmodule

[lms_adaptive_fir_top.f]
rtl/lms_pkg.sv
rtl/lms_datapath.sv
rtl/lms_ctrl.sv
rtl/lms_adaptive_fir_top.sv
tb/tb_lms_adaptive_fir_top.sv
